// File: hdl/lid_pkg.sv
// ----------------------------------------------------------------------------
// Line intersection package
// Shared types, stage counts and the saturating clip of the quotient.
// ----------------------------------------------------------------------------
package lid_pkg;

    localparam int FRONT_STAGES = 4;
    localparam int QUOT_BITS    = 33;
    localparam int DIV_STAGES   = QUOT_BITS + 1;
    localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES + 1;

    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [32:0] NEG_MAG = 33'h0_8000_0000;

    // Unsigned division job: dividend already holds the rounding term.
    typedef struct packed {
        logic [62:0] dividend;
        logic [32:0] divisor;
        logic        neg;
    } lid_div_in_t;

    typedef struct packed {
        logic [32:0] quot;
        logic        ovf;
        logic        neg;
    } lid_div_out_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } lid_coord_t;

    function automatic lid_coord_t lid_clip(input lid_div_out_t d);
        lid_coord_t r;
        logic [32:0] negq;
        negq = -d.quot;
        r.sat = 1'b0;
        if (d.ovf)
        begin
            r.sat = 1'b1;
        end
        else if (!d.neg && d.quot > {1'b0, POS_MAX})
        begin
            r.sat = 1'b1;
        end
        else if (d.neg && d.quot > NEG_MAG)
        begin
            r.sat = 1'b1;
        end
        if (r.sat)
        begin
            r.value = d.neg ? ~POS_MAX : POS_MAX;
        end
        else
        begin
            r.value = d.neg ? negq[31:0] : d.quot[31:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/line_intersection_2d.sv
// Throughput: one word per cycle unless out_stall holds it; the 34-stage
// restoring divider (a load stage and 33 quotient-bit stages) sets depth.
// Each stage loads whenever it is empty or its word moves on, so bubbles
// close up while the output is stalled.
// Reset clears all valid bits asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// Line intersection 2D
// Intersection point of two lines in normal form, saturated Q15.16.
// ----------------------------------------------------------------------------
module line_intersection_2d (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] first_normal_x,
    input  logic signed [15:0] first_normal_y,
    input  logic signed [31:0] first_offset,
    input  logic signed [15:0] second_normal_x,
    input  logic signed [15:0] second_normal_y,
    input  logic signed [31:0] second_offset,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] cross_x,
    output logic signed [31:0] cross_y,
    output logic               parallel,
    output logic               saturated
);

    localparam int NST = lid_pkg::NUM_STAGES;
    localparam int FS  = lid_pkg::FRONT_STAGES;
    localparam int DS  = lid_pkg::DIV_STAGES;

    logic [NST-1:0] v_reg;
    logic [NST:0]   ready;
    logic           par_front;
    logic [DS-1:0]  par_reg;
    lid_pkg::lid_div_in_t  jx, jy;
    lid_pkg::lid_div_out_t rx, ry;
    lid_pkg::lid_coord_t   cx, cy;
    logic [31:0] cx_reg, cy_reg;
    logic        par_out_reg, sat_reg;

    always_comb
    begin
        ready[NST] = !out_stall;
        for (int k = NST - 1; k >= 0; k--)
        begin
            ready[k] = !v_reg[k] || ready[k+1];
        end
    end

    assign in_stall = !ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (ready[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    lid_front u_front (
        .clk             (clk),
        .en              (ready[FS-1:0]),
        .first_normal_x  (first_normal_x),
        .first_normal_y  (first_normal_y),
        .first_offset    (first_offset),
        .second_normal_x (second_normal_x),
        .second_normal_y (second_normal_y),
        .second_offset   (second_offset),
        .div_x           (jx),
        .div_y           (jy),
        .parallel        (par_front)
    );

    lid_div u_div_x (
        .clk (clk),
        .en  (ready[FS+DS-1:FS]),
        .job (jx),
        .res (rx)
    );

    lid_div u_div_y (
        .clk (clk),
        .en  (ready[FS+DS-1:FS]),
        .job (jy),
        .res (ry)
    );

    // The parallel flag rides alongside the divider stages.
    always_ff @(posedge clk)
    begin
        if (ready[FS])
        begin
            par_reg[0] <= par_front;
        end
        for (int k = 1; k < DS; k++)
        begin
            if (ready[FS+k])
            begin
                par_reg[k] <= par_reg[k-1];
            end
        end
    end

    assign cx = lid_pkg::lid_clip(rx);
    assign cy = lid_pkg::lid_clip(ry);

    always_ff @(posedge clk)
    begin
        if (ready[NST-1])
        begin
            par_out_reg <= par_reg[DS-1];
            cx_reg      <= par_reg[DS-1] ? '0 : cx.value;
            cy_reg      <= par_reg[DS-1] ? '0 : cy.value;
            sat_reg     <= !par_reg[DS-1] && (cx.sat || cy.sat);
        end
    end

    assign out_valid = v_reg[NST-1];
    assign cross_x   = cx_reg;
    assign cross_y   = cy_reg;
    assign parallel  = par_out_reg;
    assign saturated = sat_reg;

    a_par_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parallel |-> cross_x == '0 && cross_y == '0 && !saturated)
        else $error("parallel result carries nonzero fields");

    a_sat_edge : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            cross_x == 32'sh7FFF_FFFF || cross_x == 32'sh8000_0000 ||
            cross_y == 32'sh7FFF_FFFF || cross_y == 32'sh8000_0000)
        else $error("saturated flag without a clipped coordinate");

    a_enter : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v_reg[0])
        else $error("accepted word did not enter the first stage");

    a_no_drop : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result word was lost");

endmodule

// File: hdl/lid_front.sv
// ----------------------------------------------------------------------------
// Line intersection front end
// Products, determinant and numerators, magnitudes, and the division setup.
// ----------------------------------------------------------------------------
module lid_front (
    input  logic                       clk,
    input  logic [3:0]                 en,
    input  logic signed [15:0]         first_normal_x,
    input  logic signed [15:0]         first_normal_y,
    input  logic signed [31:0]         first_offset,
    input  logic signed [15:0]         second_normal_x,
    input  logic signed [15:0]         second_normal_y,
    input  logic signed [31:0]         second_offset,
    output lid_pkg::lid_div_in_t       div_x,
    output lid_pkg::lid_div_in_t       div_y,
    output logic                       parallel
);

    logic signed [31:0] a1b2_reg, a2b1_reg;
    logic signed [47:0] d1b2_reg, d2b1_reg, a1d2_reg, a2d1_reg;
    logic signed [32:0] det_reg;
    logic signed [48:0] numx_reg, numy_reg;
    logic [31:0]        absd_reg;
    logic [47:0]        absx_reg, absy_reg;
    logic               negx_reg, negy_reg, par3_reg;
    logic signed [32:0] det_neg;
    logic signed [48:0] numx_neg, numy_neg;
    lid_pkg::lid_div_in_t divx_reg, divy_reg;
    logic               par4_reg;

    assign det_neg  = -det_reg;
    assign numx_neg = -numx_reg;
    assign numy_neg = -numy_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a1b2_reg <= first_normal_x * second_normal_y;
            a2b1_reg <= second_normal_x * first_normal_y;
            d1b2_reg <= first_offset * second_normal_y;
            d2b1_reg <= second_offset * first_normal_y;
            a1d2_reg <= first_normal_x * second_offset;
            a2d1_reg <= second_normal_x * first_offset;
        end
        if (en[1])
        begin
            det_reg  <= 33'(a1b2_reg) - 33'(a2b1_reg);
            numx_reg <= 49'(d1b2_reg) - 49'(d2b1_reg);
            numy_reg <= 49'(a1d2_reg) - 49'(a2d1_reg);
        end
        if (en[2])
        begin
            absd_reg <= det_reg[32] ? det_neg[31:0] : det_reg[31:0];
            absx_reg <= numx_reg[48] ? numx_neg[47:0] : numx_reg[47:0];
            absy_reg <= numy_reg[48] ? numy_neg[47:0] : numy_reg[47:0];
            negx_reg <= numx_reg[48] ^ det_reg[32];
            negy_reg <= numy_reg[48] ^ det_reg[32];
            par3_reg <= (det_reg == '0);
        end
        if (en[3])
        begin
            // Rounded quotient is (2*num*2^14 + den) / (2*den).
            divx_reg.dividend <= {absx_reg, 15'b0} + {31'b0, absd_reg};
            divy_reg.dividend <= {absy_reg, 15'b0} + {31'b0, absd_reg};
            divx_reg.divisor  <= {absd_reg, 1'b0};
            divy_reg.divisor  <= {absd_reg, 1'b0};
            divx_reg.neg      <= negx_reg;
            divy_reg.neg      <= negy_reg;
            par4_reg          <= par3_reg;
        end
    end

    assign div_x    = divx_reg;
    assign div_y    = divy_reg;
    assign parallel = par4_reg;

endmodule

// File: hdl/lid_div.sv
// ----------------------------------------------------------------------------
// Line intersection divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lid_div (
    input  logic                               clk,
    input  logic [lid_pkg::DIV_STAGES-1:0]     en,
    input  lid_pkg::lid_div_in_t               job,
    output lid_pkg::lid_div_out_t              res
);

    localparam int QB = lid_pkg::QUOT_BITS;

    logic [32:0]   rem_reg [0:QB];
    logic [QB-1:0] lo_reg  [0:QB];
    logic [32:0]   dv_reg  [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    logic          ovf_reg [0:QB];
    logic          neg_reg [0:QB];

    // The upper dividend bits must stay below the divisor, or the quotient
    // does not fit in the quotient width.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= {3'b0, job.dividend[62:QB]};
            lo_reg[0]  <= job.dividend[QB-1:0];
            dv_reg[0]  <= job.divisor;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ({3'b0, job.dividend[62:QB]} >= job.divisor);
            neg_reg[0] <= job.neg;
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_step
        logic [33:0] trial;
        logic [33:0] diff;
        logic        take;

        assign trial = {rem_reg[j-1], lo_reg[j-1][QB-j]};
        assign diff  = trial - {1'b0, dv_reg[j-1]};
        assign take  = (trial >= {1'b0, dv_reg[j-1]});

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j] <= take ? diff[32:0] : trial[32:0];
                lo_reg[j]  <= lo_reg[j-1];
                dv_reg[j]  <= dv_reg[j-1];
                q_reg[j]   <= {q_reg[j-1][QB-2:0], take};
                ovf_reg[j] <= ovf_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
        end
    end

    assign res.quot = q_reg[QB];
    assign res.ovf  = ovf_reg[QB];
    assign res.neg  = neg_reg[QB];

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line intersection 2D testbench
// Drives random and directed line pairs, predicts each intersection point
// with exact integer arithmetic and checks every result word in order.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic signed [15:0] n1x;
        logic signed [15:0] n1y;
        logic signed [31:0] d1;
        logic signed [15:0] n2x;
        logic signed [15:0] n2y;
        logic signed [31:0] d2;
    } line_pair_t;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               par;
        logic               sat;
    } crossing_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] first_normal_x;
    logic signed [15:0] first_normal_y;
    logic signed [31:0] first_offset;
    logic signed [15:0] second_normal_x;
    logic signed [15:0] second_normal_y;
    logic signed [31:0] second_offset;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    logic               parallel;
    logic               saturated;

    crossing_t expected_crossings[$];
    int        mismatch_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_cycles;
    bit        failed;

    line_intersection_2d dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .first_normal_x  (first_normal_x),
        .first_normal_y  (first_normal_y),
        .first_offset    (first_offset),
        .second_normal_x (second_normal_x),
        .second_normal_y (second_normal_y),
        .second_offset   (second_offset),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cross_x         (cross_x),
        .cross_y         (cross_y),
        .parallel        (parallel),
        .saturated       (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Rounded, saturated num * 2^14 / den.
    function automatic logic signed [31:0] quotient_q16(input longint num,
                                                        input longint den,
                                                        inout logic sat);
        logic        neg;
        logic [63:0] an;
        logic [63:0] ad;
        logic [63:0] q;
        neg = (num < 0) != (den < 0);
        an  = (num < 0 ? -num : num) << 14;
        ad  = den < 0 ? -den : den;
        q   = (2 * an + ad) / (2 * ad);
        if (!neg)
        begin
            if (q > 64'h7FFF_FFFF)
            begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return q[31:0];
        end
        if (q > 64'h8000_0000)
        begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return -q[31:0];
    endfunction

    function automatic crossing_t solve_crossing(input line_pair_t lp);
        crossing_t c;
        longint    det;
        logic      sat;
        det = longint'(lp.n1x) * lp.n2y - longint'(lp.n2x) * lp.n1y;
        sat = 1'b0;
        c.px  = '0;
        c.py  = '0;
        c.par = 1'b0;
        if (det == 0)
        begin
            c.par = 1'b1;
        end
        else
        begin
            c.px = quotient_q16(longint'(lp.d1) * lp.n2y - longint'(lp.d2) * lp.n1y,
                                det, sat);
            c.py = quotient_q16(longint'(lp.n1x) * lp.d2 - longint'(lp.n2x) * lp.d1,
                                det, sat);
        end
        c.sat = sat;
        return c;
    endfunction

    function automatic logic signed [15:0] pick_normal();
        case ($urandom_range(0, 9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            3: return 16'($urandom());
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_offset();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 2000) - 1000;
            3: return ($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_pair(input line_pair_t lp);
        while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        first_normal_x  <= lp.n1x;
        first_normal_y  <= lp.n1y;
        first_offset    <= lp.d1;
        second_normal_x <= lp.n2x;
        second_normal_y <= lp.n2y;
        second_offset   <= lp.d2;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        expected_crossings.push_back(solve_crossing(lp));
    endtask

    task automatic random_pair(output line_pair_t lp);
        lp.n1x = pick_normal();
        lp.n1y = pick_normal();
        lp.d1  = pick_offset();
        lp.n2x = pick_normal();
        lp.n2y = pick_normal();
        lp.d2  = pick_offset();
        // Parallel or nearly parallel lines now and then.
        case ($urandom_range(0, 9))
            0:
            begin
                lp.n2x = lp.n1x;
                lp.n2y = lp.n1y;
            end
            1:
            begin
                lp.n2x = -lp.n1x;
                lp.n2y = -lp.n1y;
            end
            2:
            begin
                lp.n2x = 16'(lp.n1x + $urandom_range(0, 2) - 1);
                lp.n2y = lp.n1y;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic test_directed();
        line_pair_t lp;
        lp = '{16'sd16384, 16'sd0, 32'sd65536, 16'sd0, 16'sd16384, 32'sd131072};
        send_pair(lp);
        lp = '{-16'sd16384, 16'sd0, 32'h8000_0000, 16'sd0, -16'sd16384, 32'h7FFF_FFFF};
        send_pair(lp);
        // Parallel, same and opposite normals, and both normals zero.
        lp = '{16'sd11585, 16'sd11585, 32'sd5, 16'sd11585, 16'sd11585, 32'sd9};
        send_pair(lp);
        lp = '{16'sd16384, 16'sd0, 32'sd1, -16'sd16384, 16'sd0, 32'sd1};
        send_pair(lp);
        lp = '{16'sd0, 16'sd0, 32'sd0, 16'sd0, 16'sd0, 32'sd0};
        send_pair(lp);
        // Nearly parallel: huge coordinates saturate both ways.
        lp = '{16'sd16384, 16'sd1, 32'h7FFF_FFFF, 16'sd16384, 16'sd0, 32'h8000_0000};
        send_pair(lp);
        lp = '{16'sd16384, 16'sd1, 32'h8000_0000, 16'sd16384, 16'sd0, 32'h7FFF_FFFF};
        send_pair(lp);
        // Det of 2 with small numerators, one odd and one even.
        lp = '{16'sd1, 16'sd0, 32'sd1, 16'sd0, 16'sd2, -32'sd1};
        send_pair(lp);
        lp = '{16'sd1, 16'sd0, -32'sd1, 16'sd0, 16'sd2, 32'sd3};
        send_pair(lp);
        // Non-unit normals at the raw bit pattern extremes.
        lp = '{16'sh7FFF, 16'sh8000, 32'sd12345, 16'sh8000, 16'sh7FFF, -32'sd999};
        send_pair(lp);
        lp = '{16'shFFFF, 16'sh7FFF, 32'hFFFF_FFFF, 16'sh7FFF, 16'shFFFF, 32'h5555_5555};
        send_pair(lp);
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        line_pair_t lp;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count)
        begin
            random_pair(lp);
            send_pair(lp);
        end
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall its input.
    task automatic test_backpressure();
        line_pair_t lp;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 80;
        repeat (100)
        begin
            random_pair(lp);
            send_pair(lp);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        first_normal_x  = '0;
        first_normal_y  = '0;
        first_offset    = '0;
        second_normal_x = '0;
        second_normal_y = '0;
        second_offset   = '0;
        mismatch_count  = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_cycles     = 0;
        failed          = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(350, 29, 58);
        test_random(350, 58, 29);
        test_random(350, 0, 0);
        test_backpressure();
        in_valid <= 1'b0;
        while (expected_crossings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (!failed && mismatch_count == 0)
        begin
            $display("line_intersection_2d verification clean");
        end
        else
        begin
            $display("line_intersection_2d verification failed");
        end
        $finish;
    end

    // Receiver stall: random idling, plus a long hold-off when requested.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall   <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end
            else
            begin
                out_stall <= recv_idle_pct > 0 && $urandom_range(1, 100) <= recv_idle_pct;
            end
        end
    end

    always @(posedge clk)
    begin
        crossing_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_crossings.size() == 0)
            begin
                failed <= 1'b1;
                if (mismatch_count < 10)
                begin
                    $display("unexpected result word x=%h y=%h", cross_x, cross_y);
                end
                mismatch_count <= mismatch_count + 1;
            end
            else
            begin
                e = expected_crossings.pop_front();
                if (cross_x !== e.px || cross_y !== e.py || parallel !== e.par
                    || saturated !== e.sat)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("mismatch: expected x=%h y=%h par=%b sat=%b, got x=%h y=%h par=%b sat=%b",
                                 e.px, e.py, e.par, e.sat, cross_x, cross_y,
                                 parallel, saturated);
                    end
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("line_intersection_2d verification failed");
        $finish;
    end

endmodule
